### src/q2rm_pkg.sv
// Package: constants and types for the quaternion to rotation matrix pipeline.
`timescale 1ns / 1ps
package q2rm_pkg;
  localparam int FRAC_BITS = 14;
  localparam int QW        = FRAC_BITS + 1;   // quotient bits, holds 0 .. 2^FRAC_BITS
  localparam int SW        = 33;              // sum of four squares
  localparam int DW        = SW + 1;          // divisor 2*S
  localparam int AW        = SW + QW + 1;     // dividend |N|*2^(F+1) + S
  localparam int NW        = 36;              // signed numerator
  localparam int N_EL      = 9;
  localparam logic [15:0] ONE   = 16'(1 << FRAC_BITS);
  localparam logic [QW-1:0] Q_ONE = QW'(1 << FRAC_BITS);

  typedef logic [AW-1:0] rem_t;
  typedef logic [QW-1:0] quo_t;
  typedef logic [DW-1:0] div_t;
endpackage

### src/quaternion_to_rotation_matrix.sv
// Top level: quaternion to 3x3 rotation matrix, pipelined normalize and divide.
//
//  channel | signals                          | dir | payload
//  req     | req_valid, req_ready             | in  | qx, qy, qz, qw (Q1.14)
//  rsp     | rsp_valid, rsp_ready             | out | r00..r22 (Q1.14), zero_input
//
// Steps: products, sums, 15 restoring divide steps, round/saturate.
// One request per cycle while rsp is not stalled; the divide stages (one quotient bit each) set the depth.
// Reset clears only the valid bits. A stall on rsp freezes the whole pipe and
// drops req_ready; nothing is lost or repeated.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic signed [15:0] qx,
  input  logic signed [15:0] qy,
  input  logic signed [15:0] qz,
  input  logic signed [15:0] qw,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [15:0] r00,
  output logic signed [15:0] r01,
  output logic signed [15:0] r02,
  output logic signed [15:0] r10,
  output logic signed [15:0] r11,
  output logic signed [15:0] r12,
  output logic signed [15:0] r20,
  output logic signed [15:0] r21,
  output logic signed [15:0] r22,
  output logic               zero_input
);
  localparam int QW = q2rm_pkg::QW;
  localparam int NL = q2rm_pkg::N_EL;

  logic en;
  assign en        = ~rsp_valid | rsp_ready;
  assign req_ready = en;

  // stage 1: products
  logic               vp;
  logic signed [31:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= req_valid;
    end
    if (en) begin
      xx <= qx * qx;  yy <= qy * qy;  zz <= qz * qz;  ww <= qw * qw;
      xy <= qx * qy;  xz <= qx * qz;  yz <= qy * qz;
      wx <= qw * qx;  wy <= qw * qy;  wz <= qw * qz;
    end
  end

  // stage 2: numerators, sum, dividends
  logic [q2rm_pkg::SW-1:0]        s_c;
  logic signed [q2rm_pkg::NW-1:0] s36;
  logic signed [q2rm_pkg::NW-1:0] n_c [NL];
  logic [q2rm_pkg::NW-1:0]        m_c [NL];
  q2rm_pkg::rem_t                 a_c [NL];

  always_comb begin
    s_c = q2rm_pkg::SW'($unsigned(xx)) + q2rm_pkg::SW'($unsigned(yy)) +
          q2rm_pkg::SW'($unsigned(zz)) + q2rm_pkg::SW'($unsigned(ww));
    s36 = signed'({3'b000, s_c});
    n_c[0] = s36 - ((36'(yy) + 36'(zz)) <<< 1);
    n_c[1] = (36'(xy) + 36'(wz)) <<< 1;
    n_c[2] = (36'(xz) - 36'(wy)) <<< 1;
    n_c[3] = (36'(xy) - 36'(wz)) <<< 1;
    n_c[4] = s36 - ((36'(xx) + 36'(zz)) <<< 1);
    n_c[5] = (36'(yz) + 36'(wx)) <<< 1;
    n_c[6] = (36'(xz) + 36'(wy)) <<< 1;
    n_c[7] = (36'(yz) - 36'(wx)) <<< 1;
    n_c[8] = s36 - ((36'(xx) + 36'(yy)) <<< 1);
    for (int l = 0; l < NL; l++) begin
      m_c[l] = n_c[l][q2rm_pkg::NW-1] ? 36'(-n_c[l]) : 36'(n_c[l]);
      a_c[l] = (q2rm_pkg::AW'(m_c[l][q2rm_pkg::SW-1:0]) << QW) + q2rm_pkg::AW'(s_c);
    end
  end

  // divide stages: index 0 holds the dividends, index k has k quotient bits
  logic           vd   [QW+1];
  logic           zr   [QW+1];
  q2rm_pkg::div_t dv   [QW+1];
  q2rm_pkg::rem_t rm   [QW+1][NL];
  q2rm_pkg::quo_t qt   [QW+1][NL];
  logic           ng   [QW+1][NL];

  q2rm_pkg::rem_t rm_next [QW][NL];
  q2rm_pkg::quo_t qt_next [QW][NL];
  q2rm_pkg::rem_t tr      [QW][NL];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < NL; l++) begin
        tr[k][l]      = q2rm_pkg::AW'(dv[k]) << (QW - 1 - k);
        rm_next[k][l] = rm[k][l];
        qt_next[k][l] = qt[k][l];
        if (rm[k][l] >= tr[k][l]) begin
          rm_next[k][l] = rm[k][l] - tr[k][l];
          qt_next[k][l][QW-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= vp;
      for (int k = 0; k < QW; k++) vd[k+1] <= vd[k];
    end
    if (en) begin
      zr[0] <= (s_c == '0);
      dv[0] <= {s_c, 1'b0};
      for (int l = 0; l < NL; l++) begin
        rm[0][l] <= a_c[l];
        qt[0][l] <= '0;
        ng[0][l] <= n_c[l][q2rm_pkg::NW-1];
      end
      for (int k = 0; k < QW; k++) begin
        zr[k+1] <= zr[k];
        dv[k+1] <= dv[k];
        for (int l = 0; l < NL; l++) begin
          rm[k+1][l] <= rm_next[k][l];
          qt[k+1][l] <= qt_next[k][l];
          ng[k+1][l] <= ng[k][l];
        end
      end
    end
  end

  // output stage: saturate, sign, zero override
  logic [15:0] el_c [NL];
  logic [15:0] el   [NL];
  q2rm_pkg::quo_t qs;

  always_comb begin
    qs = '0;
    for (int l = 0; l < NL; l++) begin
      qs = (qt[QW][l] > q2rm_pkg::Q_ONE) ? q2rm_pkg::Q_ONE : qt[QW][l];
      el_c[l] = ng[QW][l] ? 16'(-16'(qs)) : 16'(qs);
      if (zr[QW]) begin
        el_c[l] = (l == 0 || l == 4 || l == 8) ? q2rm_pkg::ONE : 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= vd[QW];
    end
    if (en) begin
      zero_input <= zr[QW];
      for (int l = 0; l < NL; l++) el[l] <= el_c[l];
    end
  end

  assign r00 = signed'(el[0]);
  assign r01 = signed'(el[1]);
  assign r02 = signed'(el[2]);
  assign r10 = signed'(el[3]);
  assign r11 = signed'(el[4]);
  assign r12 = signed'(el[5]);
  assign r20 = signed'(el[6]);
  assign r21 = signed'(el[7]);
  assign r22 = signed'(el[8]);

  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && zero_input |-> r00 == q2rm_pkg::ONE && r11 == q2rm_pkg::ONE &&
                                r22 == q2rm_pkg::ONE && r01 == 16'sd0 && r12 == 16'sd0)
    else $error("zero quaternion did not give identity");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> r00 <= 16'sd16384 && r00 >= -16'sd16384 &&
                  r21 <= 16'sd16384 && r21 >= -16'sd16384)
    else $error("matrix element out of range");

  a_divisor: assert property (@(posedge clk) disable iff (rst)
    vd[0] && !zr[0] |-> dv[0] != '0)
    else $error("nonzero request with zero divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vd[QW] && !en |=> vd[QW] && $stable(qt[QW][0]))
    else $error("last divide stage moved during stall");
endmodule
